@@ rtl/ftl_pkg.sv @@
// ----------------------------------------------------------------------------
// ftl_pkg: shared types and constants for the four-way traffic light FSM
// Phase codes, lamp bit positions, payload structs and the controller state.
// ----------------------------------------------------------------------------
package ftl_pkg;

  localparam int unsigned WAIT_W = 10;
  localparam logic [WAIT_W-1:0] WAIT_TICKS_RESET = 10'd60;

  // lamp vector bit positions
  localparam int unsigned LAMP_N = 0;
  localparam int unsigned LAMP_E = 1;
  localparam int unsigned LAMP_S = 2;
  localparam int unsigned LAMP_W = 3;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_N    = 3'd1,
    PH_S    = 3'd2,
    PH_E    = 3'd3,
    PH_W    = 3'd4,
    PH_NS   = 3'd5,
    PH_EW   = 3'd6
  } phase_t;

  typedef struct packed {
    logic sensor_north;
    logic sensor_east;
    logic sensor_south;
    logic sensor_west;
  } in_t;

  typedef struct packed {
    logic       lamp_north;
    logic       lamp_east;
    logic       lamp_south;
    logic       lamp_west;
    logic [2:0] phase;
    logic       holding;
  } out_t;

  typedef struct packed {
    phase_t            phase;
    phase_t            target;
    logic [WAIT_W-1:0] hold_count;
    logic [3:0]        lamps;
  } ctl_state_t;

  // green lamps that belong to a phase; unused code lights nothing
  function automatic logic [3:0] phase_lamps(input phase_t ph);
    logic [3:0] l;
    l = 4'b0000;
    case (ph)
      PH_N:    l[LAMP_N] = 1'b1;
      PH_S:    l[LAMP_S] = 1'b1;
      PH_E:    l[LAMP_E] = 1'b1;
      PH_W:    l[LAMP_W] = 1'b1;
      PH_NS: begin
        l[LAMP_N] = 1'b1;
        l[LAMP_S] = 1'b1;
      end
      PH_EW: begin
        l[LAMP_E] = 1'b1;
        l[LAMP_W] = 1'b1;
      end
      default: l = 4'b0000;
    endcase
    return l;
  endfunction

endpackage

@@ rtl/four_way_traffic_light_fsm.sv @@
// Pipeline: input register, then result register, from input transaction to result.
// Throughput: one poll per cycle unless out_stall stalls; the controller state
// advances as an item moves from the input register into the result register.
// Reset (rst, synchronous): phase idle, no hold, all lamps off, wait_ticks = 60,
// both pipeline registers empty.
// ----------------------------------------------------------------------------
// four_way_traffic_light_fsm: four-way crossing controller
// One sensor poll per input transaction, one lamp/phase result per poll.
// ----------------------------------------------------------------------------
module four_way_traffic_light_fsm (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ftl_pkg::WAIT_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  ftl_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output ftl_pkg::out_t                 out_data
);

  logic [ftl_pkg::WAIT_W-1:0] wait_ticks;
  ftl_pkg::ctl_state_t        state;
  ftl_pkg::ctl_state_t        state_next;
  ftl_pkg::out_t              res;
  logic                       s1_valid;
  ftl_pkg::in_t               s1_data;
  logic                       adv;

  // input register hands its poll to the result register
  assign adv      = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !adv;

  ftl_step u_step (
    .st         (state),
    .sens       (s1_data),
    .wait_ticks (wait_ticks),
    .st_next    (state_next),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_ticks <= ftl_pkg::WAIT_TICKS_RESET;
    end else if (cfg_we) begin
      wait_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= ftl_pkg::PH_IDLE;
      state.target     <= ftl_pkg::PH_IDLE;
      state.hold_count <= '0;
      state.lamps      <= '0;
    end else if (adv) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
    if (adv) begin
      out_data <= res;
    end
  end

  // lamps never show a direction outside the current phase
  a_lamps_in_phase: assert property (@(posedge clk) disable iff (rst)
    (state.lamps & ~ftl_pkg::phase_lamps(state.phase)) == 4'b0000)
    else $error("lamp lit outside current phase");

  // a running hold always heads for a real direction other than the current one
  a_hold_target: assert property (@(posedge clk) disable iff (rst)
    (state.hold_count != '0) |-> (state.target != ftl_pkg::PH_IDLE &&
                                  state.target != state.phase))
    else $error("hold without a valid crossing target");

  // controller state moves only with a transaction into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(state))
    else $error("state changed without a transaction");

  // the result register reflects the state it was loaded with
  a_result_phase: assert property (@(posedge clk) disable iff (rst)
    adv |=> (out_data.phase == state.phase &&
             out_data.holding == (state.hold_count != '0)))
    else $error("result does not match controller state");

endmodule

@@ rtl/ftl_step.sv @@
// ----------------------------------------------------------------------------
// ftl_step: next-state logic of the crossing controller
// Takes the current state and one sensor poll, returns the next state and the
// result of the poll.
// ----------------------------------------------------------------------------
module ftl_step (
  input  ftl_pkg::ctl_state_t           st,
  input  ftl_pkg::in_t                  sens,
  input  logic [ftl_pkg::WAIT_W-1:0]    wait_ticks,
  output ftl_pkg::ctl_state_t           st_next,
  output ftl_pkg::out_t                 res
);

  logic [ftl_pkg::WAIT_W-1:0] hold_len;
  logic [ftl_pkg::WAIT_W-1:0] cnt_dec;
  logic [3:0]                 cur_lamps;
  logic                       n, e, s, w;

  assign n = sens.sensor_north;
  assign e = sens.sensor_east;
  assign s = sens.sensor_south;
  assign w = sens.sensor_west;

  // a zero wait behaves as one tick
  assign hold_len  = (wait_ticks == '0) ? ftl_pkg::WAIT_W'(1) : wait_ticks;
  assign cnt_dec   = st.hold_count - ftl_pkg::WAIT_W'(1);
  assign cur_lamps = ftl_pkg::phase_lamps(st.phase);

  always_comb begin
    st_next = st;
    if (st.hold_count != '0) begin
      // sensors ignored while holding
      st_next.hold_count = cnt_dec;
      if (cnt_dec == '0) begin
        st_next.lamps = st.lamps & ~cur_lamps;
        st_next.phase = st.target;
      end
    end else begin
      st_next.lamps = st.lamps | cur_lamps;
      case (st.phase)
        ftl_pkg::PH_N: begin
          if (s) begin
            st_next.phase = ftl_pkg::PH_NS;
          end else if (e) begin
            st_next.target = ftl_pkg::PH_E;
            st_next.hold_count = hold_len;
          end else if (w) begin
            st_next.target = ftl_pkg::PH_W;
            st_next.hold_count = hold_len;
          end else if (!n) begin
            st_next.lamps[ftl_pkg::LAMP_N] = 1'b0;
            st_next.phase = ftl_pkg::PH_IDLE;
          end
        end
        ftl_pkg::PH_S: begin
          if (n) begin
            st_next.phase = ftl_pkg::PH_NS;
          end else if (e) begin
            st_next.target = ftl_pkg::PH_E;
            st_next.hold_count = hold_len;
          end else if (w) begin
            st_next.target = ftl_pkg::PH_W;
            st_next.hold_count = hold_len;
          end else if (!s) begin
            st_next.lamps[ftl_pkg::LAMP_S] = 1'b0;
            st_next.phase = ftl_pkg::PH_IDLE;
          end
        end
        ftl_pkg::PH_E: begin
          if (w) begin
            st_next.phase = ftl_pkg::PH_EW;
          end else if (n) begin
            st_next.target = ftl_pkg::PH_N;
            st_next.hold_count = hold_len;
          end else if (s) begin
            st_next.target = ftl_pkg::PH_S;
            st_next.hold_count = hold_len;
          end else if (!e) begin
            st_next.lamps[ftl_pkg::LAMP_E] = 1'b0;
            st_next.phase = ftl_pkg::PH_IDLE;
          end
        end
        ftl_pkg::PH_W: begin
          if (e) begin
            st_next.phase = ftl_pkg::PH_EW;
          end else if (n) begin
            st_next.target = ftl_pkg::PH_N;
            st_next.hold_count = hold_len;
          end else if (s) begin
            st_next.target = ftl_pkg::PH_S;
            st_next.hold_count = hold_len;
          end else if (!w) begin
            st_next.lamps[ftl_pkg::LAMP_W] = 1'b0;
            st_next.phase = ftl_pkg::PH_IDLE;
          end
        end
        ftl_pkg::PH_NS: begin
          if (e) begin
            st_next.target = ftl_pkg::PH_E;
            st_next.hold_count = hold_len;
          end else if (w) begin
            st_next.target = ftl_pkg::PH_W;
            st_next.hold_count = hold_len;
          end else if (!n && s) begin
            st_next.lamps[ftl_pkg::LAMP_N] = 1'b0;
            st_next.phase = ftl_pkg::PH_S;
          end else if (!s && n) begin
            st_next.lamps[ftl_pkg::LAMP_S] = 1'b0;
            st_next.phase = ftl_pkg::PH_N;
          end else if (!n && !s) begin
            st_next.lamps[ftl_pkg::LAMP_N] = 1'b0;
            st_next.lamps[ftl_pkg::LAMP_S] = 1'b0;
            st_next.phase = ftl_pkg::PH_IDLE;
          end
        end
        ftl_pkg::PH_EW: begin
          if (n) begin
            st_next.target = ftl_pkg::PH_N;
            st_next.hold_count = hold_len;
          end else if (s) begin
            st_next.target = ftl_pkg::PH_S;
            st_next.hold_count = hold_len;
          end else if (!e && w) begin
            st_next.lamps[ftl_pkg::LAMP_E] = 1'b0;
            st_next.phase = ftl_pkg::PH_W;
          end else if (!w && e) begin
            st_next.lamps[ftl_pkg::LAMP_W] = 1'b0;
            st_next.phase = ftl_pkg::PH_E;
          end else if (!w && !e) begin
            st_next.lamps[ftl_pkg::LAMP_E] = 1'b0;
            st_next.lamps[ftl_pkg::LAMP_W] = 1'b0;
            st_next.phase = ftl_pkg::PH_IDLE;
          end
        end
        default: begin
          // idle (and the unused code): N, S, E, W priority
          if (n) begin
            st_next.phase = ftl_pkg::PH_N;
          end else if (s) begin
            st_next.phase = ftl_pkg::PH_S;
          end else if (e) begin
            st_next.phase = ftl_pkg::PH_E;
          end else if (w) begin
            st_next.phase = ftl_pkg::PH_W;
          end else begin
            st_next.phase = ftl_pkg::PH_IDLE;
          end
        end
      endcase
    end
  end

  always_comb begin
    res.lamp_north = st_next.lamps[ftl_pkg::LAMP_N];
    res.lamp_east  = st_next.lamps[ftl_pkg::LAMP_E];
    res.lamp_south = st_next.lamps[ftl_pkg::LAMP_S];
    res.lamp_west  = st_next.lamps[ftl_pkg::LAMP_W];
    res.phase      = st_next.phase;
    res.holding    = (st_next.hold_count != '0);
  end

endmodule
